// File: src/assert_macros.svh
// Assertion macros shared by the keysym and Unicode lookup design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: src/khl_pkg.sv
// Types, sizes and codes shared by the keysym and Unicode lookup design.
package khl_pkg;

   localparam int KEY_INDEX_SIZE = 4096;
   localparam int UC_INDEX_SIZE  = 4096;
   localparam int RECORD_DEPTH   = 4096;

   localparam int KIW = $clog2(KEY_INDEX_SIZE);
   localparam int UIW = $clog2(UC_INDEX_SIZE);
   localparam int RW  = $clog2(RECORD_DEPTH);
   localparam int PW  = (KIW > UIW) ? KIW : UIW;

   localparam int CLEAR_DEPTH = (KEY_INDEX_SIZE > UC_INDEX_SIZE) ? KEY_INDEX_SIZE
                                                                  : UC_INDEX_SIZE;
   localparam int CLR_W = $clog2(CLEAR_DEPTH);

   localparam int MODE_W = 3;
   localparam int KS_W   = 29;
   localparam int CP_W   = 24;
   localparam int REF_W  = 12;
   localparam int ST_W   = 3;
   localparam int LIM_W  = 13;
   localparam int CSR_W  = 1;

   localparam logic [MODE_W-1:0] MODE_KEY_LOOKUP = 3'd0;
   localparam logic [MODE_W-1:0] MODE_UC_LOOKUP  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_WR_KEY_IDX = 3'd2;
   localparam logic [MODE_W-1:0] MODE_WR_UC_IDX  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_WR_RECORD  = 3'd4;

   localparam logic [ST_W-1:0] STATUS_FOUND   = 3'd0;
   localparam logic [ST_W-1:0] STATUS_MISS    = 3'd1;
   localparam logic [ST_W-1:0] STATUS_INVALID = 3'd2;
   localparam logic [ST_W-1:0] STATUS_LATIN1  = 3'd3;
   localparam logic [ST_W-1:0] STATUS_MARKER  = 3'd4;
   localparam logic [ST_W-1:0] STATUS_WRITTEN = 3'd5;

   localparam logic [CSR_W-1:0] CSR_KEY_LIMIT = 1'd0;
   localparam logic [CSR_W-1:0] CSR_UC_LIMIT  = 1'd1;

   localparam logic [LIM_W-1:0] LIMIT_RESET = 13'd16;

   localparam logic [KS_W-1:0] VOID_SYMBOL  = 29'h0ffffff;
   localparam logic [CP_W-1:0] UC_MAX       = 24'h10ffff;
   localparam logic [CP_W-1:0] UC_LOW       = 24'h000020;
   localparam logic [CP_W-1:0] UC_ASCII_END = 24'h00007e;
   localparam logic [CP_W-1:0] UC_C1_END    = 24'h0000a0;
   localparam logic [KS_W-1:0] LATIN1_END   = 29'h0000100;
   localparam logic [KS_W-1:0] UC_MARKER    = 29'h1000000;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [KS_W-1:0]   key_value;
      logic [CP_W-1:0]   code_point;
      logic [REF_W-1:0]  slot;
      logic [REF_W-1:0]  entry_ref;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [REF_W-1:0] matched_record;
      logic [KS_W-1:0]  keysym_out;
      logic [CP_W-1:0]  unicode_out;
   } rsp_type;

   typedef struct packed {
      logic idle;
      logic done;
   } eng_status_type;

endpackage

// File: src/khl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module khl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/khl_engine.sv
// Probe sequencer owning the index and record memories and the index clearing pass.
module khl_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  khl_pkg::req_type            req,
   input  logic [khl_pkg::LIM_W-1:0]   key_limit,
   input  logic [khl_pkg::LIM_W-1:0]   uc_limit,
   output khl_pkg::eng_status_type     status,
   output khl_pkg::rsp_type            result
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_IDX  = 2'd1;
   localparam logic [1:0] ST_REC  = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic                        by_uc_ff, by_uc_in;
   logic [khl_pkg::KS_W-1:0]    key_ff, key_in;
   logic [khl_pkg::PW-1:0]      pos_ff, pos_in;
   logic [khl_pkg::PW:0]        step_ff, step_in;
   logic [khl_pkg::LIM_W-1:0]   left_ff, left_in;
   logic [khl_pkg::REF_W-1:0]   rec_ff, rec_in;
   logic                        done_ff, done_in;
   khl_pkg::rsp_type            rsp_ff, rsp_in;
   logic                        clearing_ff;
   logic [khl_pkg::CLR_W-1:0]   clr_cnt_ff;

   logic                        key_we, uc_we, rec_we;
   logic                        key_wr_en, uc_wr_en;
   logic [khl_pkg::KIW-1:0]     key_wr_addr;
   logic [khl_pkg::UIW-1:0]     uc_wr_addr;
   logic [khl_pkg::REF_W-1:0]   idx_wr_data;
   logic [khl_pkg::REF_W-1:0]   key_rd_data, uc_rd_data, idx_data;
   logic [khl_pkg::KS_W+khl_pkg::CP_W-1:0] rec_rd_data;
   logic [khl_pkg::KS_W-1:0]    rec_ks;
   logic [khl_pkg::CP_W-1:0]    rec_cp;

   logic [khl_pkg::KS_W-1:0]    key_sel;
   logic [khl_pkg::PW-1:0]      start_pos;
   logic                        uc_bad;
   logic [khl_pkg::LIM_W-1:0]   limit_sel;
   logic [khl_pkg::PW:0]        size_sel;
   logic [khl_pkg::PW+1:0]      adv_sum;
   logic [khl_pkg::PW-1:0]      adv_pos;
   khl_pkg::rsp_type            miss_rsp, found_rsp, write_rsp, invalid_rsp;

   assign rec_ks   = rec_rd_data[khl_pkg::KS_W+khl_pkg::CP_W-1:khl_pkg::CP_W];
   assign rec_cp   = rec_rd_data[khl_pkg::CP_W-1:0];
   assign idx_data = by_uc_ff ? uc_rd_data : key_rd_data;

   assign key_sel = (req.key_value == khl_pkg::VOID_SYMBOL) ? '0 : req.key_value;
   assign uc_bad  = (req.code_point > khl_pkg::UC_MAX) || (req.code_point < khl_pkg::UC_LOW) ||
                    ((req.code_point > khl_pkg::UC_ASCII_END) &&
                     (req.code_point < khl_pkg::UC_C1_END));

   always_comb begin
      if (req.mode == khl_pkg::MODE_UC_LOOKUP) begin
         start_pos = khl_pkg::PW'(32'(req.code_point) % khl_pkg::UC_INDEX_SIZE);
         limit_sel = (uc_limit == '0) ? khl_pkg::LIM_W'(1) : uc_limit;
      end else begin
         start_pos = khl_pkg::PW'(32'(key_sel) % khl_pkg::KEY_INDEX_SIZE);
         limit_sel = (key_limit == '0) ? khl_pkg::LIM_W'(1) : key_limit;
      end
   end

   assign size_sel = by_uc_ff ? (khl_pkg::PW+1)'(khl_pkg::UC_INDEX_SIZE)
                              : (khl_pkg::PW+1)'(khl_pkg::KEY_INDEX_SIZE);
   assign adv_sum  = {2'b00, pos_ff} + {1'b0, step_ff};
   assign adv_pos  = (adv_sum >= {1'b0, size_sel}) ? khl_pkg::PW'(adv_sum - {1'b0, size_sel})
                                                   : khl_pkg::PW'(adv_sum);

   always_comb begin
      miss_rsp = '0;
      if (by_uc_ff) begin
         if (key_ff < khl_pkg::LATIN1_END) begin
            miss_rsp.status     = khl_pkg::STATUS_LATIN1;
            miss_rsp.keysym_out = key_ff;
         end else begin
            miss_rsp.status     = khl_pkg::STATUS_MARKER;
            miss_rsp.keysym_out = khl_pkg::UC_MARKER | key_ff;
         end
      end else begin
         miss_rsp.status = khl_pkg::STATUS_MISS;
      end
      found_rsp                = '0;
      found_rsp.status         = khl_pkg::STATUS_FOUND;
      found_rsp.matched_record = rec_ff;
      if (by_uc_ff) begin
         found_rsp.keysym_out = rec_ks;
      end else begin
         found_rsp.unicode_out = rec_cp;
      end
      write_rsp          = '0;
      write_rsp.status   = khl_pkg::STATUS_WRITTEN;
      invalid_rsp        = '0;
      invalid_rsp.status = khl_pkg::STATUS_INVALID;
   end

   always_comb begin
      state_in = state_ff;
      by_uc_in = by_uc_ff;
      key_in   = key_ff;
      pos_in   = pos_ff;
      step_in  = step_ff;
      left_in  = left_ff;
      rec_in   = rec_ff;
      done_in  = 1'b0;
      rsp_in   = rsp_ff;
      key_we   = 1'b0;
      uc_we    = 1'b0;
      rec_we   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req.mode)
                  khl_pkg::MODE_KEY_LOOKUP: begin
                     if (req.key_value == '0) begin
                        done_in = 1'b1;
                        rsp_in  = invalid_rsp;
                     end else begin
                        by_uc_in = 1'b0;
                        key_in   = key_sel;
                        pos_in   = start_pos;
                        step_in  = {1'b0, start_pos} + 1'b1;
                        left_in  = limit_sel;
                        state_in = ST_IDX;
                     end
                  end
                  khl_pkg::MODE_UC_LOOKUP: begin
                     if (uc_bad) begin
                        done_in = 1'b1;
                        rsp_in  = invalid_rsp;
                     end else begin
                        by_uc_in = 1'b1;
                        key_in   = khl_pkg::KS_W'(req.code_point);
                        pos_in   = start_pos;
                        step_in  = {1'b0, start_pos} + 1'b1;
                        left_in  = limit_sel;
                        state_in = ST_IDX;
                     end
                  end
                  khl_pkg::MODE_WR_KEY_IDX: begin
                     key_we  = 32'(req.slot) < khl_pkg::KEY_INDEX_SIZE;
                     done_in = 1'b1;
                     rsp_in  = write_rsp;
                  end
                  khl_pkg::MODE_WR_UC_IDX: begin
                     uc_we   = 32'(req.slot) < khl_pkg::UC_INDEX_SIZE;
                     done_in = 1'b1;
                     rsp_in  = write_rsp;
                  end
                  khl_pkg::MODE_WR_RECORD: begin
                     rec_we  = 32'(req.slot) < khl_pkg::RECORD_DEPTH;
                     done_in = 1'b1;
                     rsp_in  = write_rsp;
                  end
                  default: begin
                     done_in = 1'b1;
                     rsp_in  = invalid_rsp;
                  end
               endcase
            end
         end
         ST_IDX: begin
            if (idx_data == '0) begin
               done_in  = 1'b1;
               rsp_in   = miss_rsp;
               state_in = ST_IDLE;
            end else if (32'(idx_data) < khl_pkg::RECORD_DEPTH) begin
               rec_in   = idx_data;
               state_in = ST_REC;
            end else if (left_ff == khl_pkg::LIM_W'(1)) begin
               done_in  = 1'b1;
               rsp_in   = miss_rsp;
               state_in = ST_IDLE;
            end else begin
               left_in = left_ff - 1'b1;
               pos_in  = adv_pos;
            end
         end
         ST_REC: begin
            if ((by_uc_ff ? khl_pkg::KS_W'(rec_cp) : rec_ks) == key_ff) begin
               done_in  = 1'b1;
               rsp_in   = found_rsp;
               state_in = ST_IDLE;
            end else if (left_ff == khl_pkg::LIM_W'(1)) begin
               done_in  = 1'b1;
               rsp_in   = miss_rsp;
               state_in = ST_IDLE;
            end else begin
               left_in  = left_ff - 1'b1;
               pos_in   = adv_pos;
               state_in = ST_IDX;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         done_ff     <= 1'b0;
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         if (clearing_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (32'(clr_cnt_ff) == khl_pkg::CLEAR_DEPTH - 1) begin
               clearing_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      by_uc_ff <= by_uc_in;
      key_ff   <= key_in;
      pos_ff   <= pos_in;
      step_ff  <= step_in;
      left_ff  <= left_in;
      rec_ff   <= rec_in;
      rsp_ff   <= rsp_in;
   end

   assign key_wr_en   = clearing_ff ? (32'(clr_cnt_ff) < khl_pkg::KEY_INDEX_SIZE) : key_we;
   assign uc_wr_en    = clearing_ff ? (32'(clr_cnt_ff) < khl_pkg::UC_INDEX_SIZE) : uc_we;
   assign key_wr_addr = clearing_ff ? khl_pkg::KIW'(clr_cnt_ff) : khl_pkg::KIW'(req.slot);
   assign uc_wr_addr  = clearing_ff ? khl_pkg::UIW'(clr_cnt_ff) : khl_pkg::UIW'(req.slot);
   assign idx_wr_data = clearing_ff ? '0 : req.entry_ref;

   khl_ram #(
      .WIDTH (khl_pkg::REF_W),
      .DEPTH (khl_pkg::KEY_INDEX_SIZE)
   ) u_key_index (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (idx_wr_data),
      .rd_addr (khl_pkg::KIW'(pos_in)),
      .rd_data (key_rd_data)
   );

   khl_ram #(
      .WIDTH (khl_pkg::REF_W),
      .DEPTH (khl_pkg::UC_INDEX_SIZE)
   ) u_uc_index (
      .clock   (clock),
      .wr_en   (uc_wr_en),
      .wr_addr (uc_wr_addr),
      .wr_data (idx_wr_data),
      .rd_addr (khl_pkg::UIW'(pos_in)),
      .rd_data (uc_rd_data)
   );

   khl_ram #(
      .WIDTH (khl_pkg::KS_W + khl_pkg::CP_W),
      .DEPTH (khl_pkg::RECORD_DEPTH)
   ) u_records (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (khl_pkg::RW'(req.slot)),
      .wr_data ({req.key_value, req.code_point}),
      .rd_addr (khl_pkg::RW'(idx_data)),
      .rd_data (rec_rd_data)
   );

   assign status.idle = (state_ff == ST_IDLE) && !clearing_ff && !done_ff;
   assign status.done = done_ff;
   assign result      = rsp_ff;

endmodule

// File: src/keysym_unicode_hash_lookup.sv
// Top level of the keysym and Unicode hash lookup block.
//
//   Channel   Direction  Handshake             Contents
//   req_*     in         req_valid/req_stall   mode, keysym, code point, slot, entry
//   rsp_*     out        rsp_valid/rsp_stall   status, record, keysym, code point
//   csr_*     in         csr_write_en          probe limits by index
//
// Write items finish without probing; a lookup makes at most its limit of probes (zero acts as one),
// and each probe reads the index memory and then the record memory.
// After reset the index memories are cleared, and req_stall is high until that ends.
// A finished result waits in the output register while rsp_stall is high, so the
// next item is taken; a second result waits in a spare register, and items are held off until it empties.
`include "assert_macros.svh"

module keysym_unicode_hash_lookup (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [khl_pkg::MODE_W-1:0]   req_mode,
   input  logic [khl_pkg::KS_W-1:0]     req_key_value,
   input  logic [khl_pkg::CP_W-1:0]     req_code_point,
   input  logic [khl_pkg::REF_W-1:0]    req_slot,
   input  logic [khl_pkg::REF_W-1:0]    req_entry_ref,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [khl_pkg::ST_W-1:0]     rsp_status,
   output logic [khl_pkg::REF_W-1:0]    rsp_matched_record,
   output logic [khl_pkg::KS_W-1:0]     rsp_keysym_out,
   output logic [khl_pkg::CP_W-1:0]     rsp_unicode_out,
   input  logic                         csr_write_en,
   input  logic [khl_pkg::CSR_W-1:0]    csr_index,
   input  logic [khl_pkg::LIM_W-1:0]    csr_wdata
);

   logic [khl_pkg::LIM_W-1:0] key_limit_ff, uc_limit_ff;
   logic                      rsp_valid_ff, hold_valid_ff;
   khl_pkg::rsp_type          rsp_ff, hold_ff;
   khl_pkg::req_type          req;
   khl_pkg::eng_status_type   eng_status;
   khl_pkg::rsp_type          eng_result;
   logic                      req_accept, out_free;

   assign req.mode       = req_mode;
   assign req.key_value  = req_key_value;
   assign req.code_point = req_code_point;
   assign req.slot       = req_slot;
   assign req.entry_ref  = req_entry_ref;

   assign req_stall  = !eng_status.idle || hold_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_limit_ff <= khl_pkg::LIMIT_RESET;
         uc_limit_ff  <= khl_pkg::LIMIT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            khl_pkg::CSR_KEY_LIMIT: key_limit_ff <= csr_wdata;
            khl_pkg::CSR_UC_LIMIT:  uc_limit_ff  <= csr_wdata;
         endcase
      end
   end

   khl_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .req       (req),
      .key_limit (key_limit_ff),
      .uc_limit  (uc_limit_ff),
      .status    (eng_status),
      .result    (eng_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else if (hold_valid_ff && out_free) begin
         rsp_valid_ff  <= 1'b1;
         hold_valid_ff <= 1'b0;
      end else if (eng_status.done && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (eng_status.done) begin
         hold_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (hold_valid_ff && out_free) begin
         rsp_ff <= hold_ff;
      end else if (eng_status.done && out_free) begin
         rsp_ff <= eng_result;
      end
      if (eng_status.done && !out_free) begin
         hold_ff <= eng_result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_matched_record = rsp_ff.matched_record;
   assign rsp_keysym_out     = rsp_ff.keysym_out;
   assign rsp_unicode_out    = rsp_ff.unicode_out;

   `ASSERT_NEVER(a_done_hold_overlap, clock, reset, eng_status.done && hold_valid_ff)
   `ASSERT_IMPLIES(a_hold_needs_output, clock, reset, hold_valid_ff, rsp_valid_ff)
   `ASSERT_NEXT(a_accept_occupies, clock, reset, req_accept, !eng_status.idle)

endmodule
